@@ design/aip_pkg.sv @@
`timescale 1ns / 1ps

package aip_pkg;

  // Width of one text character and of the parsed result.
  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 32;

  // Accumulator width: the largest magnitude kept is 2^31, and times 16 plus 15
  // stays below 2^36.
  localparam int unsigned AccW = ValueW + 4;

  // Queue between the classifier and the parser core.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Magnitude limits for the signed 32-bit range.
  localparam logic [AccW-1:0] PosLimit = AccW'(32'h7FFF_FFFF);
  localparam logic [AccW-1:0] NegLimit = AccW'(32'h8000_0000);

  // ASCII codes that the classifier looks for.
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChLf    = 8'h0A;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;
  localparam logic [CharW-1:0] ChUpX   = 8'h58;

  // One classified character as it travels through the queue.
  typedef struct packed {
    logic       last;
    logic       is_space;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic       is_dec;
    logic       is_hexl;
    logic [3:0] dval;
  } aip_class_t;

endpackage

@@ design/aip_front.sv @@
`timescale 1ns / 1ps

module aip_front (
  input  logic [aip_pkg::CharW-1:0] ch_i,
  input  logic                      last_i,
  output aip_pkg::aip_class_t       class_o
);
  import aip_pkg::*;

  logic is_dec;
  logic is_low;
  logic is_up;

  assign is_dec = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign is_low = (ch_i >= ChLowA) && (ch_i <= ChLowF);
  assign is_up  = (ch_i >= ChUpA) && (ch_i <= ChUpF);

  always_comb begin
    class_o.last     = last_i;
    class_o.is_space = (ch_i == ChSpace) || (ch_i == ChTab) ||
                       (ch_i == ChCr) || (ch_i == ChLf);
    class_o.is_minus = (ch_i == ChMinus);
    class_o.is_zero  = (ch_i == ChZero);
    class_o.is_x     = (ch_i == ChLowX) || (ch_i == ChUpX);
    class_o.is_dec   = is_dec;
    class_o.is_hexl  = is_low || is_up;
    // Letters a..f and A..F both carry their value minus nine in the low nibble.
    class_o.dval     = is_dec ? ch_i[3:0] : 4'(ch_i[3:0] + 4'd9);
  end

endmodule

@@ design/aip_queue.sv @@
`timescale 1ns / 1ps

module aip_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  aip_pkg::aip_class_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output aip_pkg::aip_class_t head_o
);
  import aip_pkg::*;

  aip_class_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic do_push;
  logic do_pop;

  assign full_o       = (count_q == QueueCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

endmodule

@@ design/aip_back.sv @@
`timescale 1ns / 1ps

module aip_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  aip_pkg::aip_class_t        head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       valid_res_o,
  output logic signed [aip_pkg::ValueW-1:0] value_o
);
  import aip_pkg::*;

  localparam logic [2:0] PhLead   = 3'd0;
  localparam logic [2:0] PhZero   = 3'd1;
  localparam logic [2:0] PhPrefix = 3'd2;
  localparam logic [2:0] PhSign   = 3'd3;
  localparam logic [2:0] PhDigits = 3'd4;
  localparam logic [2:0] PhTrail  = 3'd5;

  logic [2:0]        phase_q, phase_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic              neg_q, neg_d;
  logic              hex_q, hex_d;
  logic              seen_q, seen_d;
  logic              failed_q, failed_d;

  logic              out_valid_q, out_valid_d;
  logic              res_ok_q;
  logic [ValueW-1:0] res_val_q;

  // State after the character alone, before the end-of-text return to idle.
  logic [2:0]        st_phase;
  logic [ValueW-1:0] st_mag;
  logic              st_neg;
  logic              st_hex;
  logic              st_seen;
  logic              st_failed;

  logic              can_emit;
  logic              is_digit;
  logic              take;
  logic [AccW-1:0]   acc_in;
  logic [AccW-1:0]   acc_scaled;
  logic [AccW-1:0]   acc_next;
  logic [AccW-1:0]   limit;
  logic              over;
  logic              ok;

  assign can_emit = !out_valid_q || !out_stall_i;
  // Only the last character of a text produces a result and needs the output slot.
  assign pop_o    = head_valid_i && (!head_i.last || can_emit);
  assign is_digit = head_i.is_dec || (hex_q && head_i.is_hexl);

  assign acc_in     = {{(AccW-ValueW){1'b0}}, mag_q};
  assign acc_scaled = hex_q ? (acc_in << 4) : ((acc_in << 3) + (acc_in << 1));
  assign acc_next   = acc_scaled + {{(AccW-4){1'b0}}, head_i.dval};
  assign limit      = neg_q ? NegLimit : PosLimit;
  assign over       = (acc_next > limit);

  always_comb begin
    st_phase  = phase_q;
    st_mag    = mag_q;
    st_neg    = neg_q;
    st_hex    = hex_q;
    st_seen   = seen_q;
    st_failed = failed_q;
    take      = 1'b0;
    if (!failed_q) begin
      unique case (phase_q)
        PhLead: begin
          if (head_i.is_space) begin
            st_phase = PhLead;
          end else if (head_i.is_minus) begin
            st_neg   = 1'b1;
            st_phase = PhSign;
          end else if (head_i.is_zero) begin
            st_mag   = '0;
            st_seen  = 1'b1;
            st_phase = PhZero;
          end else if (is_digit) begin
            take = 1'b1;
          end else begin
            st_failed = 1'b1;
          end
        end
        PhZero: begin
          if (head_i.is_x) begin
            st_hex   = 1'b1;
            st_seen  = 1'b0;
            st_mag   = '0;
            st_phase = PhPrefix;
          end else if (is_digit) begin
            take = 1'b1;
          end else if (head_i.is_space) begin
            st_phase = PhTrail;
          end else begin
            st_failed = 1'b1;
          end
        end
        PhPrefix: begin
          if (head_i.is_minus) begin
            st_neg   = 1'b1;
            st_phase = PhSign;
          end else if (is_digit) begin
            take = 1'b1;
          end else if (head_i.is_space) begin
            st_phase = PhTrail;
          end else begin
            st_failed = 1'b1;
          end
        end
        PhSign: begin
          if (is_digit) begin
            take = 1'b1;
          end else begin
            st_failed = 1'b1;
          end
        end
        PhDigits: begin
          if (is_digit) begin
            take = 1'b1;
          end else if (head_i.is_space) begin
            st_phase = PhTrail;
          end else begin
            st_failed = 1'b1;
          end
        end
        default: begin
          if (!head_i.is_space) begin
            st_failed = 1'b1;
          end
        end
      endcase
      if (take) begin
        st_seen  = 1'b1;
        st_phase = PhDigits;
        if (over) begin
          st_failed = 1'b1;
        end else begin
          st_mag = acc_next[ValueW-1:0];
        end
      end
    end
  end

  assign ok = !st_failed && st_seen;

  always_comb begin
    phase_d     = phase_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    hex_d       = hex_q;
    seen_d      = seen_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      if (head_i.last) begin
        phase_d     = PhLead;
        mag_d       = '0;
        neg_d       = 1'b0;
        hex_d       = 1'b0;
        seen_d      = 1'b0;
        failed_d    = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        phase_d  = st_phase;
        mag_d    = st_mag;
        neg_d    = st_neg;
        hex_d    = st_hex;
        seen_d   = st_seen;
        failed_d = st_failed;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhLead;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      hex_q       <= 1'b0;
      seen_q      <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      hex_q       <= hex_d;
      seen_q      <= seen_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) begin
      res_ok_q  <= ok;
      res_val_q <= ok ? (st_neg ? (ValueW'(0) - st_mag) : st_mag) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_ok_q;
  assign value_o     = res_val_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= NegLimit[ValueW-1:0])
    else $error("magnitude above the negative limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !neg_q |-> (mag_q <= PosLimit[ValueW-1:0]))
    else $error("positive magnitude out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPrefix) |-> (hex_q && !seen_q && !neg_q))
    else $error("prefix phase without hex mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_ok_q) |-> (res_val_q == '0))
    else $error("invalid result with nonzero value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && head_i.last && !can_emit) |-> !pop_o)
    else $error("end of text taken while the output slot is busy");

endmodule

@@ design/ascii_integer_parser.sv @@
`timescale 1ns / 1ps
// Path: a character marked last is written into the queue, and its result is then
//   registered in the output register.
// Throughput: one character per cycle while in_stall_o is low; the parser core updates
//   its accumulator by a shift-and-add multiply by ten or sixteen once per character.
// Reset: rst_ni is asynchronous and active low; it empties the queue and returns the
//   parser to the leading whitespace phase with no result pending.
module ascii_integer_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [aip_pkg::CharW-1:0]         ch_i,
  input  logic                              last_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  output logic                              valid_res_o,
  output logic signed [aip_pkg::ValueW-1:0] value_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i
);
  import aip_pkg::*;

  // The front end classifies each character as it arrives: whitespace, minus sign,
  // leading zero, hex prefix letter, decimal digit or hex letter, plus the digit
  // value. That classification does not depend on the parser state, so it can be
  // computed before the queue.
  aip_class_t in_class;
  aip_class_t head;
  logic       head_valid;
  logic       pop;
  logic       full;

  aip_front u_front (
    .ch_i    (ch_i),
    .last_i  (last_i),
    .class_o (in_class)
  );

  // The short queue decouples the input side from the parser core. A transfer is
  // refused only when the queue is full, which happens only while the result
  // register is held by a stalled receiver and another end of text is waiting.
  aip_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_data_i  (in_class),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  assign in_stall_o = full;

  // The parser core keeps phase, sign, base and magnitude, and writes one result
  // into its output register for every text. Characters that are not the last one
  // keep flowing even while that register waits to be taken.
  aip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .valid_res_o  (valid_res_o),
    .value_o      (value_o)
  );

endmodule

@@ sim/aip_checker.sv @@
`timescale 1ns / 1ps

module aip_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [aip_pkg::CharW-1:0]         ch_i,
  input  logic                              last_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              valid_res_i,
  input  logic signed [aip_pkg::ValueW-1:0] value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  output int unsigned                       pending_o,
  output int unsigned                       mismatch_count_o
);

  import aip_pkg::*;

  localparam int unsigned ReportLimit = 10;

  typedef enum bit [2:0] {
    PhLead,
    PhZero,
    PhPrefix,
    PhSign,
    PhDigits,
    PhTrail
  } parse_phase_e;

  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] val;
  } parse_result_t;

  // Shadow copy of the parser state.
  parse_phase_e phase;
  bit [31:0]    mag;
  bit           neg;
  bit           hex;
  bit           seen;
  bit           bad;

  parse_result_t parse_results_q[$];
  parse_result_t head;
  parse_result_t fresh;

  function automatic bit is_blank(logic [CharW-1:0] c);
    return c == ChSpace || c == ChTab || c == ChCr || c == ChLf;
  endfunction

  function automatic int digit_value(logic [CharW-1:0] c, bit h);
    if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
    if (h && c >= ChLowA && c <= ChLowF) return int'(c - ChLowA) + 10;
    if (h && c >= ChUpA && c <= ChUpF) return int'(c - ChUpA) + 10;
    return -1;
  endfunction

  task automatic clear_parse();
    phase = PhLead;
    mag   = '0;
    neg   = 1'b0;
    hex   = 1'b0;
    seen  = 1'b0;
    bad   = 1'b0;
  endtask

  // Accumulate one digit; an out-of-range magnitude marks the text bad but the
  // digit still counts as seen.
  task automatic take_digit(int d);
    longint unsigned nxt;
    longint unsigned lim;
    nxt = {32'd0, mag} * (hex ? 64'd16 : 64'd10) + 64'(d);
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (nxt > lim) bad = 1'b1;
    else mag = nxt[31:0];
    seen  = 1'b1;
    phase = PhDigits;
  endtask

  task automatic parse_char(logic [CharW-1:0] c);
    int d;
    if (bad) return;
    d = digit_value(c, hex);
    case (phase)
      PhLead: begin
        if (c == ChMinus) begin
          neg   = 1'b1;
          phase = PhSign;
        end else if (c == ChZero) begin
          mag   = '0;
          seen  = 1'b1;
          phase = PhZero;
        end else if (d >= 0) begin
          take_digit(d);
        end else if (!is_blank(c)) begin
          bad = 1'b1;
        end
      end
      PhZero: begin
        if (c == ChLowX || c == ChUpX) begin
          hex   = 1'b1;
          seen  = 1'b0;
          mag   = '0;
          phase = PhPrefix;
        end else if (d >= 0) begin
          take_digit(d);
        end else if (is_blank(c)) begin
          phase = PhTrail;
        end else begin
          bad = 1'b1;
        end
      end
      PhPrefix: begin
        if (c == ChMinus) begin
          neg   = 1'b1;
          phase = PhSign;
        end else if (d >= 0) begin
          take_digit(d);
        end else if (is_blank(c)) begin
          phase = PhTrail;
        end else begin
          bad = 1'b1;
        end
      end
      PhSign: begin
        if (d >= 0) take_digit(d);
        else bad = 1'b1;
      end
      PhDigits: begin
        if (d >= 0) take_digit(d);
        else if (is_blank(c)) phase = PhTrail;
        else bad = 1'b1;
      end
      default: begin
        if (!is_blank(c)) bad = 1'b1;
      end
    endcase
  endtask

  task automatic note_failure(string what, logic [ValueW-1:0] exp_v, logic [ValueW-1:0] act_v);
    mismatch_count_o++;
    if (mismatch_count_o <= ReportLimit) begin
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      parse_results_q.delete();
      pending_o        = 0;
      mismatch_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        parse_char(ch_i);
        if (last_i) begin
          fresh.ok  = !bad && seen;
          fresh.val = '0;
          if (fresh.ok) fresh.val = neg ? (32'd0 - mag) : mag;
          parse_results_q.push_back(fresh);
          clear_parse();
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (parse_results_q.size() == 0) begin
          note_failure("result with none pending", '0, value_i);
        end else begin
          head = parse_results_q.pop_front();
          if (valid_res_i !== head.ok) begin
            note_failure("valid_res", ValueW'(head.ok), ValueW'(valid_res_i));
          end
          if (value_i !== head.val) begin
            note_failure("value", head.val, value_i);
          end
        end
      end
      pending_o = parse_results_q.size();
    end
  end

endmodule

@@ sim/tb_ascii_integer_parser.sv @@
`timescale 1ns / 1ps

module tb_ascii_integer_parser;

  import aip_pkg::*;

  // Stop sending random text once this many characters have been transferred.
  localparam int unsigned TextChars     = 1150;
  // Cycles without any transfer on either channel before the run is declared hung.
  localparam int unsigned WatchdogLimit = 1000;
  // Extra cycles after the last result before the run ends.
  localparam int unsigned DrainCycles   = 8;
  // Length of the long receiver hold-off that fills the block up.
  localparam int unsigned HoldCycles    = 80;

  localparam logic [CharW-1:0] ChPlus = 8'h2B;
  localparam logic [CharW-1:0] ChLowG = 8'h67;

  logic                     clk;
  logic                     rst_n;
  logic [CharW-1:0]         ch;
  logic                     last;
  logic                     in_valid;
  logic                     in_stall;
  logic                     valid_res;
  logic signed [ValueW-1:0] value;
  logic                     out_valid;
  logic                     out_stall;

  int unsigned pending;
  int unsigned mismatches;

  // Characters of the text being built, sent in order with last on the final one.
  byte unsigned text_q[$];
  int unsigned  chars_sent = 0;
  // Number of upcoming characters that go out back to back.
  int unsigned  burst_left = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit           hold_req   = 1'b0;

  ascii_integer_parser u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .ch_i        (ch),
    .last_i      (last),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .valid_res_o (valid_res),
    .value_o     (value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall)
  );

  // The checker watches both channels, predicts every result and counts mismatches.
  aip_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .ch_i             (ch),
    .last_i           (last),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .valid_res_i      (valid_res),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .pending_o        (pending),
    .mismatch_count_o (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A byte that tends to land on the interesting classes: whitespace, signs,
  // prefix letters, the zero digit, a non-digit letter, or anything at all.
  function automatic byte unsigned odd_byte();
    case ($urandom_range(0, 14))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChCr;
      3:       return ChLf;
      4:       return ChMinus;
      5:       return ChPlus;
      6:       return ChLowX;
      7:       return ChUpX;
      8:       return ChZero;
      9:       return ChLowG;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_blanks(int n);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       text_q.push_back(ChSpace);
        1:       text_q.push_back(ChTab);
        2:       text_q.push_back(ChCr);
        default: text_q.push_back(ChLf);
      endcase
    end
  endfunction

  // Sends text_q as one text. Each character is driven at a falling edge and
  // held until the rising edge at which the transfer happens. A gap lowers
  // valid at the falling edge of each idle cycle, so valid is never dropped and
  // raised in the same time step.
  task automatic send_text();
    int gap;
    int r;
    bit calm;
    // Some texts go out with no idling at all.
    calm = ($urandom_range(0, 4) == 0);
    foreach (text_q[i]) begin
      gap = 0;
      if (burst_left > 0) begin
        burst_left--;
      end else if (!calm) begin
        r = $urandom_range(0, 99);
        if (r < 55) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else if (r < 98) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 40);
      end
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      @(negedge clk);
      in_valid <= 1'b1;
      ch       <= text_q[i];
      last     <= (i == text_q.size() - 1);
      do @(posedge clk); while (in_stall);
      chars_sent++;
    end
  endtask

  task automatic send_str(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // Builds one random text. Most are well-formed numbers with random base,
  // sign, padding and magnitude, the magnitude often near the signed 32-bit
  // limits or past them. Some of those get one character replaced or inserted,
  // and the rest are short runs of odd bytes or pure whitespace.
  task automatic build_random_text();
    int              r;
    int              k;
    int              d;
    int              pos;
    longint unsigned m;
    longint unsigned base;
    bit              hx;
    bit              neg;
    byte unsigned    digits[$];
    text_q.delete();
    r = $urandom_range(0, 99);
    if (r < 5) begin
      add_blanks($urandom_range(1, 4));
    end else if (r < 18) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(odd_byte());
    end else begin
      hx   = ($urandom_range(0, 2) == 0);
      neg  = ($urandom_range(0, 2) == 0);
      base = hx ? 64'd16 : 64'd10;
      k    = $urandom_range(0, 99);
      if (k < 35) m = $urandom_range(0, 999);
      else if (k < 60) m = $urandom();
      else if (k < 80) m = 64'd2147483645 + $urandom_range(0, 6);
      else m = (64'($urandom_range(0, 15)) << 32) | 64'($urandom());
      add_blanks($urandom_range(0, 3));
      if (hx) begin
        text_q.push_back(ChZero);
        text_q.push_back($urandom_range(0, 1) ? ChUpX : ChLowX);
      end
      if (neg) text_q.push_back(ChMinus);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) text_q.push_back(ChZero);
      do begin
        d = int'(m % base);
        if (d < 10) digits.push_front(8'(ChZero + d));
        else digits.push_front(8'(($urandom_range(0, 1) ? ChUpA : ChLowA) + d - 10));
        m = m / base;
      end while (m != 0);
      foreach (digits[i]) text_q.push_back(digits[i]);
      add_blanks($urandom_range(0, 3));
      // Break a share of the well-formed texts in one place.
      if (r >= 78) begin
        pos = $urandom_range(0, text_q.size() - 1);
        if ($urandom_range(0, 1)) text_q[pos] = odd_byte();
        else text_q.insert(pos, odd_byte());
      end
    end
  endtask

  // Receiver: stalls or runs free for stretches of random length, mostly
  // short, with occasional long stalls and long stall-free stretches. A hold
  // request from the stimulus forces one long stall, counted here.
  initial begin
    int run_left;
    int r;
    bit run_stall;
    run_left  = 0;
    run_stall = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        run_stall = 1'b1;
        run_left  = HoldCycles;
      end else if (run_left <= 0) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          run_stall = 1'b0;
          run_left  = $urandom_range(30, 80);
        end else begin
          run_stall = ($urandom_range(0, 2) == 0);
          r = $urandom_range(0, 99);
          if (r < 85) run_left = $urandom_range(1, 3);
          else if (r < 98) run_left = $urandom_range(4, 12);
          else run_left = $urandom_range(20, 50);
        end
      end
      out_stall <= run_stall;
      run_left--;
    end
  end

  // Watchdog: ends the run when no transfer happens on either channel for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    bit           hold_done;
    bit           drain_done;
    byte unsigned odd_bytes[3];
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    odd_bytes[0] = 8'h00;
    odd_bytes[1] = 8'h80;
    odd_bytes[2] = 8'hFF;
    ch       = '0;
    last     = 1'b0;
    in_valid = 1'b0;
    rst_n    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed texts: single digits, the range limits in both bases, overflow
    // by one and by far, bare prefix, all whitespace, misplaced and doubled signs, plus
    // sign, inner whitespace, a letter outside the base, leading zeros and a lone minus.
    send_str("0");
    send_str("7");
    send_str("-2147483648");
    send_str("2147483647");
    send_str("2147483648");
    send_str("-2147483649");
    send_str("0x7fffFFFF");
    send_str("0X-80000000");
    send_str("0x80000000");
    send_str("0xABCDEF");
    send_str("0x-0");
    send_str(" \t\r\n");
    send_str("0x");
    send_str("0x ");
    send_str("-0x1");
    send_str("12-3");
    send_str("--1");
    send_str("+5");
    send_str(" 1 2");
    send_str("0x1g");
    send_str(" 00 \t");
    send_str("99999999999");
    send_str("-");
    // NUL and bytes with the top bit set are never part of a number.
    foreach (odd_bytes[i]) begin
      text_q.delete();
      text_q.push_back(odd_bytes[i]);
      send_text();
    end

    while (chars_sent < TextChars) begin
      // Once: the receiver holds off for a long stretch while characters keep
      // coming back to back, so the block fills up and stalls its input.
      if (!hold_done && chars_sent >= 400) begin
        hold_done  = 1'b1;
        hold_req   = 1'b1;
        burst_left = 40;
      end
      // Once: the sender pauses until every pending result has come out.
      if (!drain_done && chars_sent >= 800) begin
        drain_done = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      build_random_text();
      send_text();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
